// ----- design/esc_pkg.sv -----
// types, constants and per-character check logic for the expression syntax checker
package esc_pkg;

    localparam int MAX_TEXT = 256;
    localparam int LEVEL_W  = $clog2(MAX_TEXT + 1);
    localparam int KEPT_W   = $clog2(MAX_TEXT + 2);

    localparam logic [LEVEL_W-1:0] LEVEL_MAX = LEVEL_W'(MAX_TEXT);
    localparam logic [KEPT_W-1:0]  KEPT_MAX  = KEPT_W'(MAX_TEXT);

    localparam logic [7:0] CH_NONE  = 8'h00;
    localparam logic [7:0] CH_SPACE = " ";
    localparam logic [7:0] CH_LPAR  = "(";
    localparam logic [7:0] CH_RPAR  = ")";
    localparam logic [7:0] CH_PLUS  = "+";
    localparam logic [7:0] CH_MINUS = "-";
    localparam logic [7:0] CH_STAR  = "*";
    localparam logic [7:0] CH_SLASH = "/";
    localparam logic [7:0] CH_CARET = "^";
    localparam logic [7:0] CH_DOT   = ".";
    localparam logic [7:0] CH_X     = "x";
    localparam logic [7:0] CH_E     = "e";

    localparam logic [31:0] NAME_EXP = "exp(";
    localparam logic [31:0] NAME_LOG = "log(";
    localparam logic [31:0] NAME_SIN = "sin(";
    localparam logic [31:0] NAME_COS = "cos(";
    localparam logic [31:0] NAME_TAN = "tan(";
    localparam logic [31:0] NAME_COT = "cot(";
    localparam logic [31:0] NAME_ABS = "abs(";
    localparam logic [23:0] NAME_LN  = "ln(";

    typedef struct packed {
        logic [3:0][7:0]     win;
        logic [2:0]          fill;
        logic [1:0]          skip;
        logic [7:0]          prev;
        logic [LEVEL_W-1:0]  level;
        logic                sign;
        logic                err;
    } t_chk;

    function automatic logic is_digit(logic [7:0] c);
        return (c >= "0") && (c <= "9");
    endfunction

    function automatic logic is_alpha(logic [7:0] c);
        return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
    endfunction

    function automatic logic is_alnum(logic [7:0] c);
        return is_digit(c) || is_alpha(c);
    endfunction

    function automatic logic is_space(logic [7:0] c);
        return (c == CH_SPACE) || ((c >= 8'd9) && (c <= 8'd13));
    endfunction

    function automatic logic is_op(logic [7:0] c);
        return (c == CH_CARET) || (c == CH_STAR) || (c == CH_SLASH) ||
               (c == CH_PLUS) || (c == CH_MINUS);
    endfunction

    // checks the head of the window and shifts it out
    function automatic t_chk chk_head(t_chk s);
        t_chk        r;
        logic [7:0]  cur;
        logic [7:0]  nxt;
        logic        first;
        logic        after_open;
        logic [31:0] word4;
        logic        hit4;
        logic        hit3;
        r          = s;
        cur        = s.win[0];
        nxt        = (s.fill > 3'd1) ? s.win[1] : CH_NONE;
        first      = (s.prev == CH_NONE);
        after_open = (s.prev == CH_LPAR);
        word4      = {s.win[0], s.win[1], s.win[2], s.win[3]};
        hit4       = (s.fill == 3'd4) &&
                     ((word4 == NAME_EXP) || (word4 == NAME_LOG) || (word4 == NAME_SIN) ||
                      (word4 == NAME_COS) || (word4 == NAME_TAN) || (word4 == NAME_COT) ||
                      (word4 == NAME_ABS));
        hit3       = (s.fill >= 3'd3) && (word4[31:8] == NAME_LN);
        if (s.skip != 2'd0) begin
            r.skip = s.skip - 2'd1;
            if ((r.skip == 2'd0) && (nxt == CH_RPAR)) begin
                r.err = 1'b1;
            end
        end else if (is_alpha(cur)) begin
            r.sign = 1'b0;
            if (hit4) begin
                r.skip = 2'd3;
            end else if ((cur == CH_X) || (cur == CH_E)) begin
                if (is_digit(nxt) || (nxt == CH_DOT)) begin
                    r.err = 1'b1;
                end
            end else if (hit3) begin
                r.skip = 2'd2;
            end else begin
                r.err = 1'b1;
            end
            if ((hit4 || (hit3 && (cur != CH_X) && (cur != CH_E))) && (s.level < LEVEL_MAX)) begin
                r.level = s.level + 1'b1;
            end
        end else if (is_digit(cur)) begin
            if ((nxt != CH_NONE) && !is_alnum(nxt) && !is_op(nxt) && (nxt != CH_DOT) &&
                (nxt != CH_LPAR) && (nxt != CH_RPAR)) begin
                r.err = 1'b1;
            end
            r.sign = 1'b0;
        end else if (cur == CH_LPAR) begin
            if (!is_alnum(nxt) && (nxt != CH_LPAR) && (nxt != CH_MINUS)) begin
                r.err = 1'b1;
            end
            if (s.level < LEVEL_MAX) begin
                r.level = s.level + 1'b1;
            end
            r.sign = 1'b0;
        end else if (cur == CH_RPAR) begin
            if ((s.level == '0) || is_digit(nxt)) begin
                r.err = 1'b1;
            end
            if (s.level != '0) begin
                r.level = s.level - 1'b1;
            end
        end else if ((cur == CH_PLUS) || (cur == CH_MINUS) || (cur == CH_STAR) ||
                     (cur == CH_SLASH)) begin
            if ((cur != CH_MINUS) && (first || after_open)) begin
                r.err = 1'b1;
            end
            if (s.sign || (nxt == CH_NONE) || (nxt == CH_RPAR)) begin
                r.err = 1'b1;
            end else begin
                r.sign = 1'b1;
            end
        end else if (cur == CH_DOT) begin
            if (!is_digit(nxt)) begin
                r.err = 1'b1;
            end
            r.sign = 1'b0;
        end else if (cur == CH_CARET) begin
            if (first || after_open || s.sign) begin
                r.err = 1'b1;
            end
            if (!is_alnum(nxt) && (nxt != CH_DOT) && (nxt != CH_LPAR)) begin
                r.err = 1'b1;
            end
            r.sign = 1'b0;
        end else begin
            r.err = 1'b1;
        end
        r.prev = cur;
        r.win  = {CH_NONE, s.win[3:1]};
        if (s.fill != 3'd0) begin
            r.fill = s.fill - 3'd1;
        end
        return r;
    endfunction

endpackage

// ----- design/expression_syntax_checker_top.sv -----
// expression syntax checker: streaming character checks with a result register
//
//   channel | signals                              | direction
//   --------+--------------------------------------+----------
//   input   | i_valid i_char_code i_last / o_stall | in
//   result  | o_valid o_valid_res / i_stall        | out
//
// one character request per cycle while o_stall is low, result in the cycle after the last character
// the end-of-text flush runs up to four window checks in the same cycle
// state returns to reset after every last character
// input stalls only while a result is held and the result side stalls
// synchronous active-low reset clears the window, counters and result valid
module expression_syntax_checker_top
    import esc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic [7:0] i_char_code,
    input  logic       i_last,
    output logic       o_stall,
    output logic       o_valid,
    output logic       o_valid_res,
    input  logic       i_stall
);

    t_chk              r_st, n_st;
    logic [KEPT_W-1:0] r_kept, n_kept;
    logic              r_sp, n_sp;
    logic              r_al, n_al;
    logic              r_out_valid;
    logic              r_out_res, n_out_res;

    t_chk              s_flush;
    logic              acc;
    logic              c_sp;
    logic              c_al;

    assign o_stall = r_out_valid && i_stall;
    assign acc     = i_valid && !o_stall;
    assign c_sp    = is_space(i_char_code);
    assign c_al    = is_alnum(i_char_code);

    always_comb begin
        n_st   = r_st;
        n_kept = r_kept;
        n_sp   = c_sp;
        n_al   = r_al;
        if (c_al || is_op(i_char_code)) begin
            if (r_sp && r_al && c_al) begin
                n_st.err = 1'b1;
            end
            n_al = c_al;
        end else if (!c_sp) begin
            n_al = 1'b0;
        end
        if (i_char_code == CH_NONE) begin
            n_st.err = 1'b1;
        end else if (!c_sp) begin
            if (n_st.fill == 3'd4) begin
                n_st = chk_head(n_st);
            end
            n_st.win[n_st.fill[1:0]] = i_char_code;
            n_st.fill = n_st.fill + 3'd1;
            if (n_kept <= KEPT_MAX) begin
                n_kept = n_kept + 1'b1;
            end
        end
    end

    // end-of-text flush of the remaining window and choice of the result
    always_comb begin
        s_flush = n_st;
        for (int i = 0; i < 4; i++) begin
            if (s_flush.fill != 3'd0) begin
                s_flush = chk_head(s_flush);
            end
        end
        if ((n_kept == '0) || (n_kept > KEPT_MAX)) begin
            n_out_res = 1'b0;
        end else if (n_kept == KEPT_W'(1)) begin
            n_out_res = !n_st.err && (is_digit(n_st.win[0]) || (n_st.win[0] == CH_X) ||
                                      (n_st.win[0] == CH_E));
        end else begin
            n_out_res = !s_flush.err && (s_flush.level == '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st        <= '0;
            r_kept      <= '0;
            r_sp        <= 1'b0;
            r_al        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (acc) begin
                if (i_last) begin
                    r_st   <= '0;
                    r_kept <= '0;
                    r_sp   <= 1'b0;
                    r_al   <= 1'b0;
                end else begin
                    r_st   <= n_st;
                    r_kept <= n_kept;
                    r_sp   <= n_sp;
                    r_al   <= n_al;
                end
            end
            if (acc && i_last) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc && i_last) begin
            r_out_res <= n_out_res;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_valid_res = r_out_res;

`ifndef SYNTHESIS
    a_clear_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && i_last) |=> ((r_st.fill == 3'd0) && (r_kept == '0) && !r_st.err))
        else $error("state not cleared after last character");

    a_result_from_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(acc && i_last))
        else $error("result without a last character");

    a_fill_tracks_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_kept < KEPT_W'(4)) |-> (r_st.fill == r_kept[2:0]))
        else $error("window fill out of step with kept count");

    a_skip_in_bracket: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st.skip != 2'd0) |-> (r_st.level != '0))
        else $error("name skip outside an open bracket");
`endif

endmodule
